[rtl/half_duplex_timer_uart_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the half-duplex timer UART
// Shared shorthand for concurrent assertions. The scope that uses these
// macros must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_TIMER_UART_TOP_MACROS_SVH
`define HALF_DUPLEX_TIMER_UART_TOP_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define HDTU_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define HDTU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define HDTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hdtu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtu_pkg
// Types and constants shared by the half-duplex timer UART modules.
// ----------------------------------------------------------------------------
package hdtu_pkg;

    localparam int FRAME_W = 10;

    localparam logic [3:0]         FRAME_BITS     = 4'd10;
    localparam logic [FRAME_W-1:0] TX_IDLE_FRAME  = '1;
    localparam logic [15:0]        BAUD_DIV_RESET = 16'd104;
    localparam logic [14:0]        HALF_BIT_RESET = 15'd52;

    // Configuration register indexes.
    localparam logic [0:0] CFG_BAUD_DIV = 1'b0;
    localparam logic [0:0] CFG_HALF_BIT = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_TX   = 3'b010,
        MODE_RX   = 3'b100
    } mode_t;

    typedef struct packed {
        logic [15:0] baud_div;
        logic [14:0] half_bit;
    } cfg_t;

    typedef struct packed {
        logic       tx_request;
        logic [7:0] tx_data;
        logic       rxd;
    } in_item_t;

    typedef struct packed {
        logic       txd;
        logic       tx_accepted;
        logic       tx_busy;
        logic       rx_busy;
        logic       rx_valid;
        logic [7:0] rx_data;
    } out_item_t;

endpackage

[rtl/hdtu_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtu_in_if
// Input channel: one timer tick with the transmit request and the rxd level.
// ----------------------------------------------------------------------------
interface hdtu_in_if;
    logic       valid;
    logic       ready;
    logic       tx_request;
    logic [7:0] tx_data;
    logic       rxd;

    modport source (output valid, output tx_request, output tx_data, output rxd,
                    input ready);
    modport sink (input valid, input tx_request, input tx_data, input rxd,
                  output ready);
endinterface

[rtl/hdtu_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtu_out_if
// Output channel: line level and status for one timer tick.
// ----------------------------------------------------------------------------
interface hdtu_out_if;
    logic       valid;
    logic       ready;
    logic       txd;
    logic       tx_accepted;
    logic       tx_busy;
    logic       rx_busy;
    logic       rx_valid;
    logic [7:0] rx_data;

    modport source (output valid, output txd, output tx_accepted, output tx_busy,
                    output rx_busy, output rx_valid, output rx_data, input ready);
    modport sink (input valid, input txd, input tx_accepted, input tx_busy,
                  input rx_busy, input rx_valid, input rx_data, output ready);
endinterface

[rtl/hdtu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtu_core
// Frame sequencer: shared bit timer, transmit and receive shift registers.
// State advances by one tick per accepted transaction; result is the status
// after that tick.
// ----------------------------------------------------------------------------
module hdtu_core
    import hdtu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    mode_t              mode_reg, mode_next;
    logic [15:0]        tick_count_reg, tick_count_next;
    logic [3:0]         bits_left_reg, bits_left_next;
    logic [FRAME_W-1:0] tx_shift_reg, tx_shift_next;
    logic [FRAME_W-1:0] rx_shift_reg, rx_shift_next;
    logic               rxd_prev_reg;
    logic [7:0]         rx_byte_reg, rx_byte_next;

    logic               expire;
    logic [3:0]         bits_dec;
    logic [15:0]        tick_dec;
    logic [FRAME_W-1:0] rx_sample;
    logic               accepted;
    logic               valid;

    always_comb
    begin
        mode_next       = mode_reg;
        tick_count_next = tick_count_reg;
        bits_left_next  = bits_left_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        rx_byte_next    = rx_byte_reg;
        accepted        = 1'b0;
        valid           = 1'b0;

        // A count of zero or one ends the interval, so a zero divisor acts as one.
        expire    = (tick_count_reg <= 16'd1);
        bits_dec  = bits_left_reg - 4'd1;
        tick_dec  = tick_count_reg - 16'd1;
        rx_sample = {item.rxd, rx_shift_reg[FRAME_W-1:1]};

        unique case (mode_reg)
            MODE_TX:
            begin
                if (expire)
                begin
                    tx_shift_next   = {1'b1, tx_shift_reg[FRAME_W-1:1]};
                    bits_left_next  = bits_dec;
                    tick_count_next = cfg.baud_div;
                    if (bits_dec == 4'd0)
                    begin
                        mode_next     = MODE_IDLE;
                        tx_shift_next = TX_IDLE_FRAME;
                    end
                end
                else
                begin
                    tick_count_next = tick_dec;
                end
            end
            MODE_RX:
            begin
                if (expire)
                begin
                    rx_shift_next   = rx_sample;
                    bits_left_next  = bits_dec;
                    tick_count_next = cfg.baud_div;
                    if (bits_dec == 4'd0)
                    begin
                        mode_next = MODE_IDLE;
                        // Start sample sits in bit 0, stop sample in the top bit.
                        if (!rx_sample[0] && rx_sample[FRAME_W-1])
                        begin
                            rx_byte_next = rx_sample[8:1];
                            valid        = 1'b1;
                        end
                    end
                end
                else
                begin
                    tick_count_next = tick_dec;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                // A transmit request wins over a start edge on the same tick.
                if (item.tx_request)
                begin
                    tx_shift_next   = {1'b1, item.tx_data, 1'b0};
                    bits_left_next  = FRAME_BITS;
                    tick_count_next = cfg.baud_div;
                    mode_next       = MODE_TX;
                    accepted        = 1'b1;
                end
                else if (rxd_prev_reg && !item.rxd)
                begin
                    rx_shift_next   = '0;
                    bits_left_next  = FRAME_BITS;
                    tick_count_next = {1'b0, cfg.half_bit};
                    mode_next       = MODE_RX;
                end
            end
        endcase
    end

    assign result.txd         = (mode_next == MODE_TX) ? tx_shift_next[0] : 1'b1;
    assign result.tx_accepted = accepted;
    assign result.tx_busy     = (mode_next == MODE_TX);
    assign result.rx_busy     = (mode_next == MODE_RX);
    assign result.rx_valid    = valid;
    assign result.rx_data     = rx_byte_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            tick_count_reg <= '0;
            bits_left_reg  <= '0;
            tx_shift_reg   <= TX_IDLE_FRAME;
            rx_shift_reg   <= '0;
            rxd_prev_reg   <= 1'b1;
            rx_byte_reg    <= '0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            tick_count_reg <= tick_count_next;
            bits_left_reg  <= bits_left_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            rxd_prev_reg   <= item.rxd;
            rx_byte_reg    <= rx_byte_next;
        end
    end

endmodule

[rtl/half_duplex_timer_uart_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_timer_uart_top
// Half-duplex 8N1 UART driven by one timer tick per input transaction. Each
// accepted tick advances the shared bit timer and the frame in flight by one
// step, and the line and status after that step come out as one result
// transaction. The block takes one tick per clock: the frame state updates in
// the cycle a tick is accepted, and the result sits in a single output
// register from the cycle after. din.ready drops only while that register holds a
// result that dout has not taken. The user must write the bit period and the
// half-bit delay through the cfg port only while the block is idle; the block
// itself does not enforce it. They reset to 104 and 52 ticks.
// ----------------------------------------------------------------------------
module half_duplex_timer_uart_top
    import hdtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hdtu_in_if.sink     din,
    hdtu_out_if.source  dout,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    in_item_t  item;
    out_item_t result;
    out_item_t result_reg;
    logic      out_valid_reg;
    logic      step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baud_div <= BAUD_DIV_RESET;
            cfg_reg.half_bit <= HALF_BIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BAUD_DIV: cfg_reg.baud_div <= cfg_data;
                CFG_HALF_BIT: cfg_reg.half_bit <= cfg_data[14:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign din.ready = !out_valid_reg || dout.ready;
    assign step_en   = din.valid && din.ready;

    assign item.tx_request = din.tx_request;
    assign item.tx_data    = din.tx_data;
    assign item.rxd        = din.rxd;

    hdtu_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= result;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.txd         = result_reg.txd;
    assign dout.tx_accepted = result_reg.tx_accepted;
    assign dout.tx_busy     = result_reg.tx_busy;
    assign dout.rx_busy     = result_reg.rx_busy;
    assign dout.rx_valid    = result_reg.rx_valid;
    assign dout.rx_data     = result_reg.rx_data;

endmodule

[rtl/hdtu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtu_checker
// Port-level checks on the result channel of the half-duplex timer UART.
// ----------------------------------------------------------------------------
`include "half_duplex_timer_uart_top_macros.svh"

module hdtu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       txd,
    input logic       tx_accepted,
    input logic       tx_busy,
    input logic       rx_busy,
    input logic       rx_valid,
    input logic [7:0] rx_data
);

    // The shared timer allows only one frame in flight.
    `HDTU_ASSERT_IMP(a_one_frame, out_valid, !(tx_busy && rx_busy), "tx and rx busy together")

    // An accepted request puts the start bit on the line at once.
    `HDTU_ASSERT_IMP(a_start_bit, out_valid && tx_accepted, tx_busy && !txd && !rx_busy, "accepted request without start bit")

    // A delivered byte ends reception, and the line idles high outside transmit.
    `HDTU_ASSERT_IMP(a_rx_done, out_valid && rx_valid, !rx_busy && !tx_busy && txd, "rx_valid while a frame is in flight")

    // A stalled result holds.
    `HDTU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(txd) && $stable(tx_busy) && $stable(rx_busy) && $stable(rx_valid) && $stable(rx_data), "stalled result changed")

endmodule

bind half_duplex_timer_uart_top hdtu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .txd         (dout.txd),
    .tx_accepted (dout.tx_accepted),
    .tx_busy     (dout.tx_busy),
    .rx_busy     (dout.rx_busy),
    .rx_valid    (dout.rx_valid),
    .rx_data     (dout.rx_data)
);

[dv/tb_half_duplex_timer_uart_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_half_duplex_timer_uart_top
// Self-checking bench for the half-duplex timer UART. A queue of timer ticks
// feeds the input channel, and a cycle-level model of the UART predicts the
// line level and status for every accepted tick. Runs cover the reset state,
// zero divisors, refused requests, good and broken receive frames, and the
// largest bit time, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_half_duplex_timer_uart_top;
    import hdtu_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    hdtu_in_if  tick_if ();
    hdtu_out_if status_if ();

    half_duplex_timer_uart_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (tick_if),
        .dout      (status_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state: configuration copy and the shared bit timer.
    logic [15:0] baud_ticks;
    logic [14:0] sample_delay;
    mode_t       line_mode;
    logic [15:0] ticks_left;
    logic [3:0]  bits_left;
    logic [9:0]  tx_frame;
    logic [9:0]  rx_frame;
    logic        rxd_last;
    logic [7:0]  last_byte;

    in_item_t    ticks_to_send[$];
    out_item_t   expected_status[$];
    in_item_t    next_tick;
    in_item_t    seen_tick;
    out_item_t   seen_status;
    logic        tick_taken;

    int unsigned ticks_queued;
    int unsigned ticks_accepted;
    int unsigned failures;
    int unsigned frames_sent;
    int unsigned bytes_received;
    int unsigned reg_writes;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    always #5 clk = ~clk;

    function automatic logic coin(input int unsigned pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic int unsigned bit_len();
        return (baud_ticks == 16'd0) ? 1 : int'(baud_ticks);
    endfunction

    // True when the running interval ends on this tick; otherwise count down.
    function automatic logic interval_done();
        if (ticks_left <= 16'd1)
            return 1'b1;
        ticks_left = ticks_left - 16'd1;
        return 1'b0;
    endfunction

    function automatic out_item_t next_line_status(input in_item_t t);
        out_item_t s;
        logic      taken;
        logic      got_byte;
        taken    = 1'b0;
        got_byte = 1'b0;
        case (line_mode)
            MODE_TX:
            begin
                if (interval_done())
                begin
                    tx_frame   = {1'b1, tx_frame[9:1]};
                    bits_left  = bits_left - 4'd1;
                    ticks_left = baud_ticks;
                    if (bits_left == 4'd0)
                    begin
                        line_mode = MODE_IDLE;
                        tx_frame  = TX_IDLE_FRAME;
                    end
                end
            end
            MODE_RX:
            begin
                if (interval_done())
                begin
                    rx_frame   = {t.rxd, rx_frame[9:1]};
                    bits_left  = bits_left - 4'd1;
                    ticks_left = baud_ticks;
                    if (bits_left == 4'd0)
                    begin
                        line_mode = MODE_IDLE;
                        // Start sample must be low and stop sample high.
                        if (!rx_frame[0] && rx_frame[9])
                        begin
                            last_byte = rx_frame[8:1];
                            got_byte  = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                line_mode = MODE_IDLE;
                if (t.tx_request)
                begin
                    tx_frame   = {1'b1, t.tx_data, 1'b0};
                    bits_left  = FRAME_BITS;
                    ticks_left = baud_ticks;
                    line_mode  = MODE_TX;
                    taken      = 1'b1;
                end
                else if (rxd_last && !t.rxd)
                begin
                    rx_frame   = '0;
                    bits_left  = FRAME_BITS;
                    ticks_left = {1'b0, sample_delay};
                    line_mode  = MODE_RX;
                end
            end
        endcase
        rxd_last = t.rxd;

        s.txd         = (line_mode == MODE_TX) ? tx_frame[0] : 1'b1;
        s.tx_accepted = taken;
        s.tx_busy     = (line_mode == MODE_TX);
        s.rx_busy     = (line_mode == MODE_RX);
        s.rx_valid    = got_byte;
        s.rx_data     = last_byte;
        if (taken)
            frames_sent++;
        if (got_byte)
            bytes_received++;
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic check_status(input out_item_t got);
        out_item_t want;
        if (expected_status.size() == 0)
        begin
            $error("status transaction arrived with nothing expected");
            failures++;
            return;
        end
        want = expected_status.pop_front();
        check_field("txd", want.txd, got.txd);
        check_field("tx_accepted", want.tx_accepted, got.tx_accepted);
        check_field("tx_busy", want.tx_busy, got.tx_busy);
        check_field("rx_busy", want.rx_busy, got.rx_busy);
        check_field("rx_valid", want.rx_valid, got.rx_valid);
        check_field("rx_data", want.rx_data, got.rx_data);
    endtask

    task automatic add_tick(input logic req, input logic [7:0] data, input logic rxd);
        in_item_t t;
        t.tx_request = req;
        t.tx_data    = data;
        t.rxd        = rxd;
        ticks_to_send.push_back(t);
        ticks_queued++;
    endtask

    task automatic wait_for_drain();
        while (ticks_accepted != ticks_queued || expected_status.size() != 0)
            @(negedge clk);
    endtask

    // Drain the channels, then feed quiet ticks until no frame is in flight.
    task automatic finish_frames();
        int unsigned remaining;
        wait_for_drain();
        while (line_mode != MODE_IDLE)
        begin
            remaining = int'(ticks_left) + int'(bits_left) * bit_len() + 1;
            repeat (remaining) add_tick(1'b0, rand_byte(), 1'b1);
            wait_for_drain();
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_BAUD_DIV)
            baud_ticks = value;
        else
            sample_delay = value[14:0];
        reg_writes++;
    endtask

    // Serial waveform of one 8N1 frame on rxd, cut short after bits_sent bits.
    task automatic send_rx_frame(input logic [7:0] value, input logic start_ok,
                                 input logic stop_ok, input int unsigned bits_sent,
                                 input int unsigned start_len);
        logic [9:0]  levels;
        int unsigned len;
        levels = {stop_ok, value, 1'b0};
        repeat (2) add_tick(1'b0, rand_byte(), 1'b1);
        for (int i = 0; i < bits_sent; i++)
        begin
            len = (i == 0) ? start_len : bit_len();
            for (int j = 0; j < len; j++)
                add_tick(coin(12), rand_byte(),
                         (i == 0 && j > 0 && !start_ok) ? 1'b1 : levels[i]);
        end
    endtask

    task automatic send_tx_frame(input logic [7:0] value);
        add_tick(1'b0, rand_byte(), 1'b1);
        add_tick(1'b1, value, 1'b1);
        repeat (10 * bit_len()) add_tick(coin(12), rand_byte(), !coin(10));
    endtask

    task automatic run_random_phase(input int unsigned tick_budget);
        int unsigned first;
        first = ticks_queued;
        while (ticks_queued - first < tick_budget)
        begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3: send_rx_frame(rand_byte(), 1'b1, 1'b1, 10, bit_len());
                4, 5, 6:    send_tx_frame(rand_byte());
                7:          send_rx_frame(rand_byte(), coin(50), coin(50),
                                          $urandom_range(10, 1), bit_len());
                default:    repeat ($urandom_range(6, 1))
                                add_tick(coin(30), rand_byte(), coin(50));
            endcase
        end
        finish_frames();
    endtask

    // Input driver: a tick stays on the channel until a transaction takes it.
    always @(negedge clk)
    begin
        if (rst_n && (!tick_if.valid || tick_taken))
        begin
            if (ticks_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                next_tick = ticks_to_send.pop_front();
                tick_if.valid      <= 1'b1;
                tick_if.tx_request <= next_tick.tx_request;
                tick_if.tx_data    <= next_tick.tx_data;
                tick_if.rxd        <= next_tick.rxd;
            end
            else
                tick_if.valid <= 1'b0;
        end
        status_if.ready <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Monitor: predict on every accepted tick, check every accepted result.
    always @(posedge clk)
    begin
        tick_taken <= tick_if.valid && tick_if.ready;
        if (rst_n)
        begin
            if (tick_if.valid && tick_if.ready)
            begin
                seen_tick.tx_request = tick_if.tx_request;
                seen_tick.tx_data    = tick_if.tx_data;
                seen_tick.rxd        = tick_if.rxd;
                expected_status.push_back(next_line_status(seen_tick));
                ticks_accepted++;
            end
            if (status_if.valid && status_if.ready)
            begin
                seen_status.txd         = status_if.txd;
                seen_status.tx_accepted = status_if.tx_accepted;
                seen_status.tx_busy     = status_if.tx_busy;
                seen_status.rx_busy     = status_if.rx_busy;
                seen_status.rx_valid    = status_if.rx_valid;
                seen_status.rx_data     = status_if.rx_data;
                check_status(seen_status);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out with %0d ticks unsent and %0d results outstanding.",
                 ticks_queued - ticks_accepted, expected_status.size());
        $display("[half_duplex_timer_uart_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [15:0] baud;
        logic [14:0] delay;

        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_BAUD_DIV;
        cfg_data           = '0;
        tick_if.valid      = 1'b0;
        tick_if.tx_request = 1'b0;
        tick_if.tx_data    = '0;
        tick_if.rxd        = 1'b1;
        status_if.ready    = 1'b0;
        tick_taken         = 1'b0;
        ticks_queued       = 0;
        ticks_accepted     = 0;
        failures           = 0;
        frames_sent        = 0;
        bytes_received     = 0;
        reg_writes         = 0;

        baud_ticks   = BAUD_DIV_RESET;
        sample_delay = HALF_BIT_RESET;
        line_mode    = MODE_IDLE;
        ticks_left   = '0;
        bits_left    = '0;
        tx_frame     = TX_IDLE_FRAME;
        rx_frame     = '0;
        rxd_last     = 1'b1;
        last_byte    = '0;

        send_idle_pct  = 38;
        recv_stall_pct = 45;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Right after reset the line idles high with nothing busy.
        repeat (4) add_tick(1'b0, rand_byte(), 1'b1);
        finish_frames();

        // Zero divisors act as one tick.
        write_reg(CFG_BAUD_DIV, 16'd0);
        write_reg(CFG_HALF_BIT, 16'd0);
        add_tick(1'b1, 8'h00, 1'b1);
        // Request and falling edge while sending: both ignored.
        add_tick(1'b1, 8'hFF, 1'b0);
        repeat (9) add_tick(1'b0, 8'h00, 1'b1);
        // Request and falling edge on the same idle tick: transmit wins.
        add_tick(1'b1, 8'hFF, 1'b0);
        finish_frames();
        send_rx_frame(8'h81, 1'b1, 1'b0, 10, 1);
        send_rx_frame(8'h7E, 1'b1, 1'b1, 10, 1);
        finish_frames();

        for (int phase = 0; phase < 8; phase++)
        begin
            send_idle_pct  = (phase < 3) ? 38 : (phase < 6) ? 45 : 0;
            recv_stall_pct = (phase < 3) ? 45 : (phase < 6) ? 38 : 0;
            if (phase == 0)
                baud = 16'd2;
            else if (phase == 1)
                baud = 16'd1;
            else
                baud = 16'($urandom_range(4, 3));
            delay = (baud == 16'd1) ? 15'd0 : 15'($urandom_range(baud, 1));
            write_reg(CFG_BAUD_DIV, baud);
            write_reg(CFG_HALF_BIT, {coin(50), delay});
            run_random_phase(20);
        end

        // Largest bit time: the start bit holds and a second request is refused.
        write_reg(CFG_BAUD_DIV, 16'hFFFF);
        add_tick(1'b0, rand_byte(), 1'b1);
        add_tick(1'b1, rand_byte(), 1'b1);
        repeat (12) add_tick(1'b0, rand_byte(), coin(50));
        add_tick(1'b1, rand_byte(), 1'b1);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (expected_status.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_status.size());
            failures++;
        end
        $display("Checked %0d ticks over %0d register writes.", ticks_accepted, reg_writes);
        $display("Frames sent: %0d, bytes received: %0d, mismatches: %0d.",
                 frames_sent, bytes_received, failures);
        if (failures == 0)
            $display("[half_duplex_timer_uart_top] OK");
        else
            $display("[half_duplex_timer_uart_top] ERROR");
        $finish;
    end

endmodule
